### rtl/core/jsu_pkg.sv
package jsu_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;
  localparam int PUSH_MAX   = 5;
  localparam int ROOM_LIMIT = FIFO_DEPTH - PUSH_MAX;
  localparam int RES_MAX    = 8;
  localparam int HELD_N     = 6;
  localparam int CP_W       = 21;

  localparam logic [15:0] CAP_RESET = 16'd4096;

  localparam logic [7:0] CHAR_BSL   = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_N     = 8'h6E;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_R     = 8'h72;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] CHAR_F     = 8'h66;
  localparam logic [7:0] CTRL_LF    = 8'h0A;
  localparam logic [7:0] CTRL_TAB   = 8'h09;
  localparam logic [7:0] CTRL_CR    = 8'h0D;
  localparam logic [7:0] CTRL_BS    = 8'h08;
  localparam logic [7:0] CTRL_FF    = 8'h0C;

  localparam logic [15:0] SURR_LO      = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST = 16'hDBFF;
  localparam logic [15:0] SURR_LO_1ST  = 16'hDC00;
  localparam logic [15:0] SURR_LAST    = 16'hDFFF;
  localparam logic [CP_W-1:0] CP_REPL  = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_PLANE1 = 21'h010000;

  typedef enum logic [3:0] {
    PH_PLAIN = 4'b0001,
    PH_BSL   = 4'b0010,
    PH_HEX   = 4'b0100,
    PH_PAIR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       done;
    logic       outc;
  } res_t;

  typedef struct packed {
    logic [2:0]       n;
    res_t [PUSH_MAX-1:0] ent;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexd_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  function automatic hexd_t hex_val(input logic [7:0] c);
    hexd_t r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      r.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      r.ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      r.ok = 1'b1;
    end
    r.val = t[3:0];
    return r;
  endfunction

  function automatic enc_t utf8_enc(input logic [CP_W-1:0] cp);
    enc_t r;
    logic [CP_W-1:0] v;
    r = '0;
    v = cp;
    if (cp >= {5'b0, SURR_LO} && cp <= {5'b0, SURR_LAST}) begin
      v = CP_REPL;
    end
    if (v < 21'h80) begin
      r.n = 3'd1;
      r.b[0] = v[7:0];
    end else if (v < 21'h800) begin
      r.n = 3'd2;
      r.b[0] = 8'hC0 | {3'b0, v[10:6]};
      r.b[1] = 8'h80 | {2'b0, v[5:0]};
    end else if (v < CP_PLANE1) begin
      r.n = 3'd3;
      r.b[0] = 8'hE0 | {4'b0, v[15:12]};
      r.b[1] = 8'h80 | {2'b0, v[11:6]};
      r.b[2] = 8'h80 | {2'b0, v[5:0]};
    end else begin
      r.n = 3'd4;
      r.b[0] = 8'hF0 | {5'b0, v[20:18]};
      r.b[1] = 8'h80 | {2'b0, v[17:12]};
      r.b[2] = 8'h80 | {2'b0, v[11:6]};
      r.b[3] = 8'h80 | {2'b0, v[5:0]};
    end
    return r;
  endfunction

endpackage

### rtl/core/jsu_res_fifo.sv
module jsu_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::push_t push,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output jsu_pkg::res_t out_res
);

  jsu_pkg::res_t mem [jsu_pkg::FIFO_DEPTH];
  logic [jsu_pkg::FIFO_AW-1:0] wp_r, wp_nxt;
  logic [jsu_pkg::FIFO_AW-1:0] rp_r, rp_nxt;
  logic [jsu_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= jsu_pkg::FIFO_CW'(jsu_pkg::ROOM_LIMIT));
  assign out_res   = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + jsu_pkg::FIFO_AW'(push.n);
    rp_nxt  = rp_r + jsu_pkg::FIFO_AW'(pop);
    cnt_nxt = cnt_r + jsu_pkg::FIFO_CW'(push.n) - jsu_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < jsu_pkg::PUSH_MAX; i++) begin
      if (3'(i) < push.n) begin
        mem[wp_r + jsu_pkg::FIFO_AW'(i)] <= push.ent[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != '0) |-> ({1'b0, cnt_r} + {2'b0, push.n} <= 5'(jsu_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= jsu_pkg::FIFO_CW'(jsu_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");
`endif

endmodule

### rtl/core/json_string_unescape_utf8.sv
// an accepted byte is registered; its results then enter the result queue, whose head drives the outputs
// throughput: one byte per cycle while each byte gives at most one result and the result queue has room
// a failed escape replays its held bytes through the decoder, one per cycle while the result queue has room
// an open value at end of buffer is resolved in a later step; results drain one per cycle unless out_stall
// reset (rst_n, synchronous, active low) clears decoder and queue state, capacity 4096
module json_string_unescape_utf8 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_value_done,
  output logic        out_outcome
);

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [9:0]  pend_r, pend_nxt;
  logic [47:0] held_r, held_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [15:0] bw_r, bw_nxt;
  logic        fin_r, fin_nxt;
  logic [15:0] cap_r;
  logic        it_vld_r, it_vld_nxt;
  logic        it_last_r, it_last_nxt;
  logic [47:0] q_r, q_nxt;
  logic [2:0]  qlen_r, qlen_nxt;
  jsu_pkg::res_t tail_r, tail_nxt;
  logic        tail_vld_r, tail_vld_nxt;
  logic [3:0]  rc_r, rc_nxt;

  logic        room;
  logic        op_go;
  logic        step_end;
  logic        accept;
  jsu_pkg::push_t push;
  jsu_pkg::res_t  head;

  assign op_go    = it_vld_r && room;
  assign in_stall = it_vld_r && !(op_go && step_end);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [7:0]  c;
    jsu_pkg::hexd_t hd;
    logic [2:0]  k;
    logic [15:0] acc;
    logic        fail;
    logic        do_byte;
    logic [7:0]  eb;
    logic        do_cp;
    logic [jsu_pkg::CP_W-1:0] cp;
    logic        fin_e;
    logic        oc;
    logic        rep;
    logic [2:0]  rep_n;
    logic [47:0] rep_src;
    logic [47:0] q_rest;
    logic [2:0]  qrest_len;
    jsu_pkg::enc_t enc;
    logic [3:0][7:0] nb;
    logic [2:0]  m;
    logic [3:0]  avail;
    logic [2:0]  m_keep;
    jsu_pkg::res_t [3:0] ne;
    jsu_pkg::res_t [jsu_pkg::PUSH_MAX-1:0] lst;
    logic [2:0]  ln;
    logic        done_only;
    jsu_pkg::phase_t ph_n;
    logic [15:0] hex_n;
    logic [9:0]  pend_n;
    logic [47:0] held_n;
    logic [2:0]  hcnt_n;
    logic [15:0] bw_n;
    logic [47:0] q_n;
    logic [3:0]  qlen_w;

    c = q_r[7:0];
    hd = jsu_pkg::hex_val(c);
    k = '0;
    acc = '0;
    fail = 1'b0;
    do_byte = 1'b0;
    eb = '0;
    do_cp = 1'b0;
    cp = '0;
    fin_e = 1'b0;
    oc = 1'b0;
    rep = 1'b0;
    rep_n = '0;
    rep_src = held_r;
    q_rest = q_r;
    qrest_len = qlen_r;
    enc = '0;
    nb = '0;
    m = '0;
    ph_n = phase_r;
    hex_n = hex_r;
    pend_n = pend_r;
    held_n = held_r;
    hcnt_n = hcnt_r;
    bw_n = bw_r;

    if (fin_r) begin
      // value already closed: byte dropped
    end else if (qlen_r != '0) begin
      q_rest = q_r >> 8;
      qrest_len = qlen_r - 3'd1;
      unique case (phase_r)
        jsu_pkg::PH_PLAIN: begin
          if ({1'b0, bw_r} + 17'd1 >= {1'b0, cap_r}) begin
            fin_e = 1'b1;
            oc = 1'b1;
          end else if (c == jsu_pkg::CHAR_BSL) begin
            ph_n = jsu_pkg::PH_BSL;
          end else if (c == jsu_pkg::CHAR_QUOTE) begin
            fin_e = 1'b1;
          end else begin
            do_byte = 1'b1;
            eb = c;
          end
        end
        jsu_pkg::PH_BSL: begin
          ph_n = jsu_pkg::PH_PLAIN;
          do_byte = 1'b1;
          case (c)
            jsu_pkg::CHAR_N: eb = jsu_pkg::CTRL_LF;
            jsu_pkg::CHAR_T: eb = jsu_pkg::CTRL_TAB;
            jsu_pkg::CHAR_R: eb = jsu_pkg::CTRL_CR;
            jsu_pkg::CHAR_B: eb = jsu_pkg::CTRL_BS;
            jsu_pkg::CHAR_F: eb = jsu_pkg::CTRL_FF;
            jsu_pkg::CHAR_U: begin
              do_byte = 1'b0;
              ph_n = jsu_pkg::PH_HEX;
              hcnt_n = '0;
              hex_n = '0;
            end
            default: eb = c;
          endcase
        end
        jsu_pkg::PH_HEX: begin
          k = {1'b0, hcnt_r[1:0]};
          held_n = (held_r & ~(48'hFF << {k, 3'b000})) | ({40'b0, c} << {k, 3'b000});
          if (!hd.ok) begin
            ph_n = jsu_pkg::PH_PLAIN;
            do_byte = 1'b1;
            eb = jsu_pkg::CHAR_U;
            rep = 1'b1;
            rep_n = k + 3'd1;
            rep_src = held_n;
            hcnt_n = '0;
          end else begin
            acc = {hex_r[11:0], hd.val};
            hex_n = acc;
            hcnt_n = k + 3'd1;
            if (k == 3'd3) begin
              ph_n = jsu_pkg::PH_PLAIN;
              hcnt_n = '0;
              if (acc >= jsu_pkg::SURR_LO && acc <= jsu_pkg::SURR_HI_LAST) begin
                ph_n = jsu_pkg::PH_PAIR;
                pend_n = acc[9:0];
                hex_n = '0;
              end else begin
                do_cp = 1'b1;
                cp = {5'b0, acc};
              end
            end
          end
        end
        jsu_pkg::PH_PAIR: begin
          k = (hcnt_r > 3'd5) ? 3'd5 : hcnt_r;
          held_n = (held_r & ~(48'hFF << {k, 3'b000})) | ({40'b0, c} << {k, 3'b000});
          fail = ((k == 3'd0) && (c != jsu_pkg::CHAR_BSL)) ||
                 ((k == 3'd1) && (c != jsu_pkg::CHAR_U)) ||
                 ((k >= 3'd2) && !hd.ok);
          if (fail) begin
            ph_n = jsu_pkg::PH_PLAIN;
            do_cp = 1'b1;
            cp = jsu_pkg::CP_REPL;
            rep = 1'b1;
            rep_n = k + 3'd1;
            rep_src = held_n;
            hcnt_n = '0;
          end else begin
            acc = (k >= 3'd2) ? {hex_r[11:0], hd.val} : 16'h0000;
            hex_n = acc;
            hcnt_n = k + 3'd1;
            if (k == 3'd5) begin
              ph_n = jsu_pkg::PH_PLAIN;
              hcnt_n = '0;
              do_cp = 1'b1;
              if (acc >= jsu_pkg::SURR_LO_1ST && acc <= jsu_pkg::SURR_LAST) begin
                cp = jsu_pkg::CP_PLANE1 + {1'b0, pend_r, acc[9:0]};
              end else begin
                cp = jsu_pkg::CP_REPL;
                rep = 1'b1;
                rep_n = 3'd6;
                rep_src = held_n;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else if (it_last_r) begin
      // end of buffer with the value still open
      qrest_len = '0;
      hcnt_n = '0;
      ph_n = jsu_pkg::PH_PLAIN;
      unique case (phase_r)
        jsu_pkg::PH_PLAIN: begin
          fin_e = 1'b1;
          oc = 1'b1;
        end
        jsu_pkg::PH_BSL: begin
          do_byte = 1'b1;
          eb = jsu_pkg::CHAR_BSL;
        end
        jsu_pkg::PH_HEX: begin
          do_byte = 1'b1;
          eb = jsu_pkg::CHAR_U;
          rep = 1'b1;
          rep_n = hcnt_r;
        end
        jsu_pkg::PH_PAIR: begin
          do_cp = 1'b1;
          cp = jsu_pkg::CP_REPL;
          rep = 1'b1;
          rep_n = hcnt_r;
        end
        default: begin
        end
      endcase
    end

    // emission and room checks
    if (do_byte) begin
      nb[0] = eb;
      m = 3'd1;
      bw_n = bw_r + 16'd1;
      if ({1'b0, bw_n} + 17'd1 >= {1'b0, cap_r}) begin
        fin_e = 1'b1;
        oc = 1'b1;
      end
    end else if (do_cp) begin
      if ({1'b0, bw_r} + 17'd4 >= {1'b0, cap_r}) begin
        fin_e = 1'b1;
        oc = 1'b1;
      end else begin
        enc = jsu_pkg::utf8_enc(cp);
        nb = enc.b;
        m = enc.n;
        bw_n = bw_r + {13'b0, enc.n};
        if ({1'b0, bw_n} + 17'd1 >= {1'b0, cap_r}) begin
          fin_e = 1'b1;
          oc = 1'b1;
        end
      end
    end

    if (fin_e) begin
      ph_n = jsu_pkg::PH_PLAIN;
      hcnt_n = '0;
    end

    q_n = q_rest;
    qlen_w = {1'b0, qrest_len};
    if (rep && !fin_e) begin
      q_n = (rep_src & ~(48'hFFFF_FFFF_FFFF << {rep_n, 3'b000})) |
            (q_rest << {rep_n, 3'b000});
      qlen_w = {1'b0, rep_n} + {1'b0, qrest_len};
      hcnt_n = '0;
    end

    // result list: held-back tail first, then new bytes
    avail = 4'(jsu_pkg::RES_MAX) - rc_r;
    m_keep = ({1'b0, m} > avail) ? avail[2:0] : m;
    for (int j = 0; j < 4; j++) begin
      ne[j].data = nb[j];
      ne[j].has  = 1'b1;
      ne[j].done = 1'b0;
      ne[j].outc = 1'b0;
    end
    if (tail_vld_r) begin
      lst = {ne[3], ne[2], ne[1], ne[0], tail_r};
    end else begin
      lst = {jsu_pkg::res_t'('0), ne[3], ne[2], ne[1], ne[0]};
    end
    ln = {2'b0, tail_vld_r} + m_keep;
    done_only = 1'b0;
    if (fin_e) begin
      if (ln == '0) begin
        if (rc_r < 4'(jsu_pkg::RES_MAX)) begin
          lst[0] = '{data: 8'h00, has: 1'b0, done: 1'b1, outc: oc};
          ln = 3'd1;
          done_only = 1'b1;
        end
      end else begin
        lst[ln - 3'd1].done = 1'b1;
        lst[ln - 3'd1].outc = oc;
      end
    end

    step_end = fin_r || fin_e || ((qlen_w == '0) && !it_last_r);

    push.ent = lst;
    push.n = '0;
    tail_nxt = tail_r;
    tail_vld_nxt = tail_vld_r;
    rc_nxt = rc_r;
    phase_nxt = phase_r;
    hex_nxt = hex_r;
    pend_nxt = pend_r;
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    bw_nxt = bw_r;
    fin_nxt = fin_r;
    q_nxt = q_r;
    qlen_nxt = qlen_r;
    it_vld_nxt = it_vld_r;
    it_last_nxt = it_last_r;

    if (op_go) begin
      phase_nxt = ph_n;
      hex_nxt = hex_n;
      pend_nxt = pend_n;
      held_nxt = held_n;
      hcnt_nxt = hcnt_n;
      bw_nxt = bw_n;
      fin_nxt = fin_r || fin_e;
      q_nxt = q_n;
      qlen_nxt = qlen_w[2:0];
      if (step_end) begin
        push.n = ln;
        tail_vld_nxt = 1'b0;
        rc_nxt = '0;
        it_vld_nxt = 1'b0;
        if (it_last_r) begin
          phase_nxt = jsu_pkg::PH_PLAIN;
          hex_nxt = '0;
          pend_nxt = '0;
          hcnt_nxt = '0;
          bw_nxt = '0;
          fin_nxt = 1'b0;
        end
      end else begin
        rc_nxt = rc_r + {1'b0, m_keep} + {3'b0, done_only};
        if (ln != '0) begin
          push.n = ln - 3'd1;
          tail_nxt = lst[ln - 3'd1];
          tail_vld_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jsu_pkg::PH_PLAIN;
      hex_r      <= '0;
      pend_r     <= '0;
      hcnt_r     <= '0;
      bw_r       <= '0;
      fin_r      <= 1'b0;
      cap_r      <= jsu_pkg::CAP_RESET;
      it_vld_r   <= 1'b0;
      qlen_r     <= '0;
      tail_vld_r <= 1'b0;
      rc_r       <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hex_r      <= hex_nxt;
      pend_r     <= pend_nxt;
      hcnt_r     <= hcnt_nxt;
      bw_r       <= bw_nxt;
      fin_r      <= fin_nxt;
      if (cfg_wr_en) begin
        cap_r    <= cfg_wr_data;
      end
      if (accept) begin
        it_vld_r <= 1'b1;
        qlen_r   <= 3'd1;
      end else begin
        it_vld_r <= it_vld_nxt;
        qlen_r   <= qlen_nxt;
      end
      tail_vld_r <= tail_vld_nxt;
      rc_r       <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r    <= held_nxt;
    tail_r    <= tail_nxt;
    if (accept) begin
      q_r       <= {40'b0, in_byte};
      it_last_r <= in_end_of_buffer;
    end else begin
      q_r       <= q_nxt;
      it_last_r <= it_last_nxt;
    end
  end

  jsu_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (head)
  );

  assign out_byte       = head.data;
  assign out_has_byte   = head.has;
  assign out_value_done = head.done;
  assign out_outcome    = head.outc;

`ifndef SYNTHESIS
  a_fin_plain: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (phase_r == jsu_pkg::PH_PLAIN && hcnt_r == '0))
    else $error("closed value left an escape open");
  a_tail_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld_r |-> it_vld_r)
    else $error("held result outside a transaction");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (op_go && step_end && it_last_r && !accept) |=>
      (bw_r == '0 && !fin_r && phase_r == jsu_pkg::PH_PLAIN && !it_vld_r))
    else $error("end of buffer did not clear the value");
  a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rc_r <= 4'(jsu_pkg::RES_MAX)) && (qlen_r <= 3'(jsu_pkg::HELD_N)))
    else $error("result or replay count out of range");
`endif

endmodule

### test/json_string_unescape_utf8_checker.sv
module json_string_unescape_utf8_checker
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_buffer,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_has_byte,
  input  logic        out_value_done,
  input  logic        out_outcome,
  output int          mismatches,
  output int          awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OUTC_OK   = 1'b0;
  localparam logic OUTC_OPEN = 1'b1;

  logic [15:0] capacity;
  phase_t      phase;
  logic [15:0] hex_acc;
  logic [15:0] high_half;
  logic [7:0]  held [HELD_N];
  int          held_n;
  logic [15:0] written;
  logic        finished;
  int          fail_count;

  res_t        produced [$];
  logic [7:0]  replay_q [$];
  res_t        expected_bytes [$];

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) return {1'b1, c[3:0] + 4'd9};
    return 5'b0;
  endfunction

  function void add_out(logic [7:0] b, logic h, logic d, logic oc);
    res_t r;
    if (produced.size() >= RES_MAX) return;
    r.data = b;
    r.has  = h;
    r.done = d;
    r.outc = oc;
    produced.push_back(r);
  endfunction

  function void close_value(logic oc);
    res_t tail;
    finished = 1'b1;
    phase    = PH_PLAIN;
    held_n   = 0;
    if (produced.size() > 0 && !produced[produced.size() - 1].done) begin
      tail = produced[produced.size() - 1];
      tail.done = 1'b1;
      tail.outc = oc;
      produced[produced.size() - 1] = tail;
    end else begin
      add_out(8'h00, 1'b0, 1'b1, oc);
    end
  endfunction

  function void put_raw(logic [7:0] b);
    add_out(b, 1'b1, 1'b0, OUTC_OK);
    written = written + 16'd1;
  endfunction

  function void room_check();
    if (int'(written) + 1 >= int'(capacity)) close_value(OUTC_OPEN);
  endfunction

  function void emit_char(logic [7:0] b);
    put_raw(b);
    room_check();
  endfunction

  function void emit_code(logic [CP_W-1:0] cp);
    logic [CP_W-1:0] v;
    v = cp;
    if (int'(written) + 4 >= int'(capacity)) begin
      close_value(OUTC_OPEN);
      return;
    end
    if (v >= {5'b0, SURR_LO} && v <= {5'b0, SURR_LAST}) v = CP_REPL;
    if (v < 21'h80) begin
      put_raw(v[7:0]);
    end else if (v < 21'h800) begin
      put_raw({3'b110, v[10:6]});
      put_raw({2'b10, v[5:0]});
    end else if (v < CP_PLANE1) begin
      put_raw({4'b1110, v[15:12]});
      put_raw({2'b10, v[11:6]});
      put_raw({2'b10, v[5:0]});
    end else begin
      put_raw({5'b11110, v[20:18]});
      put_raw({2'b10, v[17:12]});
      put_raw({2'b10, v[11:6]});
      put_raw({2'b10, v[5:0]});
    end
    room_check();
  endfunction

  // held bytes go back in front of whatever is still waiting
  function void replay(int n);
    int m;
    int i;
    m = (n > HELD_N) ? HELD_N : n;
    for (i = m - 1; i >= 0; i--) replay_q.push_front(held[i]);
    held_n = 0;
  endfunction

  function void decode(logic [7:0] c);
    int k;
    logic [4:0] nib;
    logic [15:0] hi_off;
    logic [15:0] lo_off;
    case (phase)
      PH_PLAIN: begin
        if (int'(written) + 1 >= int'(capacity)) close_value(OUTC_OPEN);
        else if (c == CHAR_BSL) phase = PH_BSL;
        else if (c == CHAR_QUOTE) close_value(OUTC_OK);
        else emit_char(c);
      end
      PH_BSL: begin
        phase = PH_PLAIN;
        case (c)
          CHAR_N: emit_char(CTRL_LF);
          CHAR_T: emit_char(CTRL_TAB);
          CHAR_R: emit_char(CTRL_CR);
          CHAR_B: emit_char(CTRL_BS);
          CHAR_F: emit_char(CTRL_FF);
          CHAR_U: begin
            phase   = PH_HEX;
            held_n  = 0;
            hex_acc = '0;
          end
          default: emit_char(c);
        endcase
      end
      PH_HEX: begin
        k = held_n & 3;
        held[k] = c;
        nib = nibble_of(c);
        if (!nib[4]) begin
          phase = PH_PLAIN;
          emit_char(CHAR_U);
          if (!finished) replay(k + 1);
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          held_n = k + 1;
          if (held_n == 4) begin
            phase  = PH_PLAIN;
            held_n = 0;
            if (hex_acc >= SURR_LO && hex_acc <= SURR_HI_LAST) begin
              phase     = PH_PAIR;
              high_half = hex_acc;
              hex_acc   = '0;
            end else begin
              emit_code({5'b0, hex_acc});
            end
          end
        end
      end
      default: begin
        k = (held_n > 5) ? 5 : held_n;
        held[k] = c;
        nib = nibble_of(c);
        if ((k == 0 && c != CHAR_BSL) || (k == 1 && c != CHAR_U) || (k >= 2 && !nib[4])) begin
          phase = PH_PLAIN;
          emit_code(CP_REPL);
          if (!finished) replay(k + 1);
        end else begin
          if (k >= 2) hex_acc = {hex_acc[11:0], nib[3:0]};
          else hex_acc = '0;
          held_n = k + 1;
          if (held_n == 6) begin
            phase = PH_PLAIN;
            if (hex_acc >= SURR_LO_1ST && hex_acc <= SURR_LAST) begin
              held_n = 0;
              hi_off = high_half - SURR_LO;
              lo_off = hex_acc - SURR_LO_1ST;
              emit_code(CP_PLANE1 + {1'b0, hi_off[9:0], lo_off[9:0]});
            end else begin
              emit_code(CP_REPL);
              if (!finished) replay(6);
            end
          end
        end
      end
    endcase
  endfunction

  // escape still open when the buffer ends
  function void resolve_cutoff();
    phase_t was;
    was   = phase;
    phase = PH_PLAIN;
    if (was == PH_BSL) begin
      held_n = 0;
      emit_char(CHAR_BSL);
    end else if (was == PH_HEX) begin
      emit_char(CHAR_U);
      if (!finished) replay(held_n);
    end else begin
      emit_code(CP_REPL);
      if (!finished) replay(held_n);
    end
  endfunction

  function void clear_value();
    phase     = PH_PLAIN;
    hex_acc   = '0;
    high_half = '0;
    held_n    = 0;
    written   = '0;
    finished  = 1'b0;
  endfunction

  function void decode_input_byte(logic [7:0] b, logic eob);
    int i;
    produced.delete();
    if (!finished) begin
      replay_q.delete();
      replay_q.push_back(b);
      while (!finished) begin
        if (replay_q.size() > 0) decode(replay_q.pop_front());
        else if (!eob) break;
        else if (phase != PH_PLAIN) resolve_cutoff();
        else close_value(OUTC_OPEN);
      end
    end
    if (eob) clear_value();
    for (i = 0; i < produced.size(); i++) expected_bytes.push_back(produced[i]);
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      capacity = CAP_RESET;
      clear_value();
      foreach (held[i]) held[i] = '0;
      expected_bytes.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_valid && !in_stall) decode_input_byte(in_byte, in_end_of_buffer);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected transaction, out_byte %h", out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data)
            report($sformatf("out_byte %h, expected %h", out_byte, want.data));
          if (out_has_byte !== want.has)
            report($sformatf("out_has_byte %b, expected %b", out_has_byte, want.has));
          if (out_value_done !== want.done)
            report($sformatf("out_value_done %b, expected %b", out_value_done, want.done));
          if (out_outcome !== want.outc)
            report($sformatf("out_outcome %b, expected %b", out_outcome, want.outc));
        end
      end
    end
    mismatches <= fail_count;
    awaited    <= expected_bytes.size();
  end

endmodule

### test/json_string_unescape_utf8_tb.sv
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         PHASE_BYTES  = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_has_byte;
  logic        out_value_done;
  logic        out_outcome;
  int          mismatches;
  int          awaited;

  int          idle_pct = 10;
  int          sent = 0;
  int          cycles = 0;
  logic [7:0]  chunk [$];
  logic [15:0] cap_steps [9] = '{16'd65535, 16'd1, 16'd0, 16'd3, 16'd6, 16'd12, 16'd0, 16'd200,
                                 16'd4096};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  json_string_unescape_utf8 dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .in_end_of_buffer(in_end_of_buffer),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_has_byte(out_has_byte), .out_value_done(out_value_done), .out_outcome(out_outcome)
  );

  json_string_unescape_utf8_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .in_end_of_buffer(in_end_of_buffer),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_has_byte(out_has_byte), .out_value_done(out_value_done), .out_outcome(out_outcome),
    .mismatches(mismatches), .awaited(awaited)
  );

  // result side backpressure bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return CHAR_QUOTE;
    if ($urandom_range(0, 3) == 0) return CHAR_BSL;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46));
    return c;
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 7))
      0: return CHAR_N;
      1: return CHAR_T;
      2: return CHAR_R;
      3: return CHAR_B;
      4: return CHAR_F;
      5: return CHAR_QUOTE;
      6: return CHAR_BSL;
      default: return CHAR_SLASH;
    endcase
  endfunction

  function automatic void push_text(int n);
    logic [7:0] c;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == CHAR_BSL || c == CHAR_QUOTE) c = 8'h2E;
      chunk.push_back(c);
    end
  endfunction

  function automatic void push_escape(logic [7:0] c);
    chunk.push_back(CHAR_BSL);
    chunk.push_back(c);
  endfunction

  function automatic void push_digits(int n);
    repeat (n) chunk.push_back(hex_char(4'($urandom_range(0, 15))));
  endfunction

  function automatic void push_u(logic [15:0] v);
    push_escape(CHAR_U);
    chunk.push_back(hex_char(v[15:12]));
    chunk.push_back(hex_char(v[11:8]));
    chunk.push_back(hex_char(v[7:4]));
    chunk.push_back(hex_char(v[3:0]));
  endfunction

  function automatic logic [15:0] bmp_code();
    logic [15:0] v;
    case ($urandom_range(0, 2))
      0: v = 16'($urandom_range(0, 16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      default: v = 16'($urandom_range(16'h800, 16'hFFFF));
    endcase
    if (v >= SURR_LO && v <= SURR_LAST) v = v ^ 16'h4000;
    return v;
  endfunction

  function automatic logic [15:0] high_code();
    return SURR_LO + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic void add_piece();
    int pick;
    logic [7:0] c;
    pick = $urandom_range(0, 19);
    if (pick <= 5 || pick >= 17) begin
      push_text($urandom_range(1, 4));
    end else if (pick <= 7) begin
      push_escape(simple_escape());
    end else if (pick == 8) begin
      c = 8'($urandom_range(0, 255));
      if (c == CHAR_U) c = 8'h78;
      push_escape(c);
    end else if (pick <= 10) begin
      push_u(bmp_code());
    end else if (pick <= 12) begin
      push_u(high_code());
      push_u(SURR_LO_1ST + 16'($urandom_range(0, 16'h3FF)));
    end else if (pick == 13) begin
      push_u(high_code());
      case ($urandom_range(0, 3))
        0: push_text($urandom_range(1, 3));
        1: push_u($urandom_range(0, 1) ? bmp_code() : high_code());
        2: push_escape(simple_escape());
        default: chunk.push_back(CHAR_QUOTE);
      endcase
    end else if (pick == 14) begin
      push_u(SURR_LO_1ST + 16'($urandom_range(0, 16'h3FF)));
    end else if (pick == 15) begin
      push_escape(CHAR_U);
      push_digits($urandom_range(0, 3));
      chunk.push_back(non_hex());
    end else begin
      push_u(high_code());
      push_escape(CHAR_U);
      push_digits($urandom_range(0, 3));
      chunk.push_back(non_hex());
    end
  endfunction

  function automatic void make_value();
    int ending;
    chunk.delete();
    repeat ($urandom_range(0, 6)) add_piece();
    ending = $urandom_range(0, 9);
    if (ending <= 6) begin
      chunk.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 3)) chunk.push_back(8'($urandom_range(0, 255)));
    end else if (ending == 7) begin
      case ($urandom_range(0, 2))
        0: chunk.push_back(CHAR_BSL);
        1: begin
          push_escape(CHAR_U);
          push_digits($urandom_range(0, 3));
        end
        default: begin
          push_u(high_code());
          case ($urandom_range(0, 2))
            0: chunk.push_back(CHAR_BSL);
            1: begin
              push_escape(CHAR_U);
              push_digits($urandom_range(0, 3));
            end
            default: ;
          endcase
        end
      endcase
    end
    if (chunk.size() == 0) chunk.push_back(8'h61);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_value();
    for (int i = 0; i < chunk.size(); i++) send_byte(chunk[i], i == chunk.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // extremes of the byte, unknown escape, closing quote
    chunk = '{8'h00, 8'hFF, CHAR_BSL, 8'h71, CHAR_QUOTE};
    send_value();
    // highest code point from a pair, then end of buffer with the value open
    chunk.delete();
    push_u(16'hDBFF);
    push_u(16'hDFFF);
    send_value();
    // cut-off hex escape
    chunk = '{CHAR_BSL, CHAR_U, 8'h31};
    send_value();
    // lone backslash at end of buffer
    chunk = '{CHAR_BSL};
    send_value();
    // empty value, trailing byte dropped
    chunk = '{CHAR_QUOTE, 8'h78};
    send_value();

    for (int p = 0; p < 9; p++) begin
      settle();
      if (p == 6) write_cap(16'($urandom_range(1, 40)));
      else write_cap(cap_steps[p]);
      idle_pct = (p == 3 || p == 8) ? 0 : 10;
      start = sent;
      while (sent - start < PHASE_BYTES) begin
        make_value();
        send_value();
      end
    end

    settle();
    if (mismatches == 0 && awaited == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_res_fifo.sv
rtl/core/json_string_unescape_utf8.sv
test/json_string_unescape_utf8_checker.sv
test/json_string_unescape_utf8_tb.sv
